// File: design/link_state_route_engine_core_assert.svh
// Assertion macros used by the checker file of the route engine.
`ifndef LINK_STATE_ROUTE_ENGINE_CORE_ASSERT_SVH
`define LINK_STATE_ROUTE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define LSRE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define LSRE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lsre_pkg.sv
// ----------------------------------------------------------------------------
// Link-state route engine package
// Sizes, codes, sequencer states and helper functions of the route engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lsre_pkg;

    localparam int NODES    = 64;
    localparam int ID_W     = 6;
    localparam int NODE_W   = $clog2(NODES);
    localparam int CNT_W    = $clog2(NODES + 1);
    localparam int ADDR_W   = $clog2(NODES * NODES);
    localparam int COST_W   = 32;
    localparam int STAMP_W  = 31;
    localparam int DIST_W   = 40;
    localparam int IN_W     = 80;
    localparam int OUT_W    = 120;

    localparam logic [STAMP_W-1:0] CLOCK_MAX = {STAMP_W{1'b1}};
    localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};
    localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};

    localparam logic [2:0] OP_REMOTE = 3'd0;
    localparam logic [2:0] OP_LOCAL  = 3'd1;
    localparam logic [2:0] OP_LIVE   = 3'd2;
    localparam logic [2:0] OP_BEAT   = 3'd3;
    localparam logic [2:0] OP_LOOKUP = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WR_FWD,
        ST_WR_REV,
        ST_RB_INIT,
        ST_RB_X,
        ST_RB_XD,
        ST_RB_Y,
        ST_RB_DRAIN,
        ST_WK_I,
        ST_WK_R,
        ST_WK_S,
        ST_DONE
    } state_t;

    // Flat address of the link table entry from node a to node b.
    function automatic logic [ADDR_W-1:0] edge_addr(input logic [ID_W-1:0] a,
                                                    input logic [ID_W-1:0] b);
        return ADDR_W'(int'(a) * NODES + int'(b));
    endfunction

    // True when the id names an existing node.
    function automatic logic node_ok(input logic [ID_W-1:0] v);
        return int'(v) < NODES;
    endfunction

    // Saturating increment of the logical clock.
    function automatic logic [STAMP_W-1:0] sat_inc(input logic [STAMP_W-1:0] v);
        return (v == CLOCK_MAX) ? CLOCK_MAX : v + STAMP_W'(1);
    endfunction

endpackage

`default_nettype wire

// File: design/link_state_route_engine_core.sv
// Link-state route engine. The slave side is not ready while a transfer is
// in progress. A lookup, heartbeat or rejected update passes the read, evaluate
// and done states; a link write that leaves the cost unchanged also writes the
// forward and reverse entries. A cost change rebuilds the routes: an init sweep
// over the path entries, then n rounds (n known nodes) over all 64 candidate
// parents, each scanning all 64 targets at one relaxation per cycle, then a
// parent walk of up to 64 steps per node. The single read port of the distance
// memory and the shared adder and comparator set this pace.
// After reset a clearing pass over all 4096 entries initializes the link table
// while no transfer is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// Link-state route engine core
// Link table, logical clock, Bellman-Ford rebuild and next-hop lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module link_state_route_engine_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lsre_pkg::ID_W-1:0]   cfg_wr_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // src_node[5:0], dst_node[11:6], link_cost[43:12], stamp[74:44], alive[75]
    input  wire logic [lsre_pkg::IN_W-1:0]   s_tdata,
    // opcode[2:0]
    input  wire logic [2:0]                  s_tuser,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // next_hop[5:0], reachable[6], accepted[7], send_update[8], update_src[14:9],
    // update_dst[20:15], update_cost[52:21], update_stamp[83:53], clock_now[114:84]
    output logic [lsre_pkg::OUT_W-1:0]       m_tdata
);
    import lsre_pkg::*;

    // Sequencer and item registers.
    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [ID_W-1:0]           my_id_reg;
    logic [2:0]                op_reg, op_next;
    logic [ID_W-1:0]           src_reg, src_next, dst_reg, dst_next;
    logic signed [COST_W-1:0]  cost_reg, cost_next;
    logic [STAMP_W-1:0]        stamp_reg, stamp_next;
    logic                      alive_reg, alive_next;
    logic [STAMP_W-1:0]        clock_reg, clock_next;

    // Edge write and result registers.
    logic [ID_W-1:0]           es_reg, es_next, ed_reg, ed_next;
    logic signed [COST_W-1:0]  ec_reg, ec_next, prev_reg, prev_next;
    logic [STAMP_W-1:0]        est_reg, est_next;
    logic                      acc_reg, acc_next, send_reg, send_next;
    logic                      reach_reg, reach_next;
    logic [ID_W-1:0]           nh_reg, nh_next;

    // Node tables.
    logic [NODES-1:0]          known_reg, known_next;
    logic [NODES-1:0]          hop_valid_reg, hop_valid_next;
    logic [NODES-1:0]          inf_reg, inf_next;

    // Next-hop memory, meaningful only where the valid bit is set.
    logic [ID_W-1:0]           hop_mem [NODES];
    logic [ID_W-1:0]           hop_rd_reg;
    logic                      hop_we;

    // Rebuild loop registers.
    logic [CNT_W-1:0]          n_reg, n_next, k_reg, k_next, steps_reg, steps_next;
    logic [NODE_W-1:0]         x_reg, x_next, y_reg, y_next;
    logic [DIST_W-1:0]         dist_a_reg, dist_a_next;
    logic                      p_valid_reg, p_valid_next;
    logic [ID_W-1:0]           p_b_reg, p_b_next;
    logic [ID_W-1:0]           last_reg, last_next, cur_reg, cur_next;
    logic                      has_reg, has_next;

    // Output register.
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]          out_data_reg, out_data_next;

    // Link memory: {stamp, cost} per directed entry.
    logic [STAMP_W+COST_W-1:0] edge_mem [NODES*NODES];
    logic [STAMP_W+COST_W-1:0] edge_rd_reg;
    logic                      edge_we;
    logic [ADDR_W-1:0]         edge_wa, edge_ra;
    logic [STAMP_W+COST_W-1:0] edge_wd;

    // Path memory: {parent valid, parent, distance} per node.
    logic [DIST_W+ID_W:0]      path_mem [NODES];
    logic [DIST_W+ID_W:0]      path_rd_reg;
    logic                      path_we;
    logic [NODE_W-1:0]         path_wa, path_ra;
    logic [DIST_W+ID_W:0]      path_wd;

    // Shared decode.
    logic                      in_xfer;
    logic [ID_W-1:0]           rd_s, node_a, node_x, node_y;
    logic signed [COST_W-1:0]  stored_cost, live_mag, relax_c;
    logic [STAMP_W-1:0]        stored_stamp, clock_inc, beat_val;
    logic                      item_ok, x_last, relax_hit;
    logic [DIST_W-1:0]         relax_nd, relax_db;

    assign in_xfer      = s_tvalid && s_tready;
    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = out_data_reg;
    assign rd_s         = (op_reg == OP_REMOTE) ? src_reg : my_id_reg;
    assign node_x       = ID_W'(x_reg);
    assign node_y       = ID_W'(y_reg);
    assign node_a       = node_x;
    assign stored_cost  = edge_rd_reg[COST_W-1:0];
    assign stored_stamp = edge_rd_reg[STAMP_W+COST_W-1:COST_W];
    assign clock_inc    = sat_inc(clock_reg);
    assign beat_val     = sat_inc(stamp_reg);
    assign x_last       = (x_reg == NODE_W'(NODES - 1));
    assign item_ok      = node_ok(rd_s) && node_ok(dst_reg);

    // Magnitude of the stored cost, saturated for the most negative value.
    always_comb
    begin
        if (stored_cost == COST_MIN)
            live_mag = COST_MAX;
        else if (stored_cost < 0)
            live_mag = -stored_cost;
        else
            live_mag = stored_cost;
    end

    // Relaxation unit: one candidate edge per cycle.
    assign relax_c  = edge_rd_reg[COST_W-1:0];
    assign relax_db = path_rd_reg[DIST_W-1:0];
    assign relax_nd = dist_a_reg + DIST_W'(unsigned'(relax_c));
    always_comb
    begin
        relax_hit = 1'b0;
        if (p_valid_reg && relax_c >= 0)
        begin
            relax_hit = inf_reg[p_b_reg] || (relax_nd < relax_db) ||
                        ((relax_nd == relax_db) && path_rd_reg[DIST_W+ID_W] &&
                         (path_rd_reg[DIST_W+ID_W-1:DIST_W] > node_a));
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == ADDR_W'(NODES * NODES - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_xfer)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
            begin
                state_next = ST_DONE;
                if (item_ok)
                begin
                    if ((op_reg == OP_REMOTE && stored_stamp < stamp_reg) ||
                        op_reg == OP_LOCAL || op_reg == OP_LIVE)
                        state_next = ST_WR_FWD;
                end
            end
            ST_WR_FWD:
                state_next = ST_WR_REV;
            ST_WR_REV:
                state_next = (prev_reg != ec_reg) ? ST_RB_INIT : ST_DONE;
            ST_RB_INIT:
                if (x_last)
                    state_next = ST_RB_X;
            ST_RB_X:
            begin
                if (known_reg[node_x] && !inf_reg[node_x])
                    state_next = ST_RB_XD;
                else if (x_last && (k_reg + CNT_W'(1) >= n_reg))
                    state_next = ST_WK_I;
            end
            ST_RB_XD:
                state_next = ST_RB_Y;
            ST_RB_Y:
                if (y_reg == NODE_W'(NODES - 1))
                    state_next = ST_RB_DRAIN;
            ST_RB_DRAIN:
                state_next = (x_last && (k_reg + CNT_W'(1) >= n_reg)) ? ST_WK_I : ST_RB_X;
            ST_WK_I:
            begin
                if (node_x != my_id_reg)
                    state_next = ST_WK_R;
                else if (x_last)
                    state_next = ST_DONE;
            end
            ST_WK_R:
                state_next = ST_WK_S;
            ST_WK_S:
            begin
                if (has_reg && steps_reg != CNT_W'(NODES) && cur_reg != my_id_reg)
                    state_next = ST_WK_R;
                else
                    state_next = x_last ? ST_DONE : ST_WK_I;
            end
            ST_DONE:
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control of each state.
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        op_next       = op_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        cost_next     = cost_reg;
        stamp_next    = stamp_reg;
        alive_next    = alive_reg;
        clock_next    = clock_reg;
        es_next       = es_reg;
        ed_next       = ed_reg;
        ec_next       = ec_reg;
        est_next      = est_reg;
        prev_next     = prev_reg;
        acc_next      = acc_reg;
        send_next     = send_reg;
        reach_next    = reach_reg;
        nh_next       = nh_reg;
        known_next    = known_reg;
        hop_valid_next = hop_valid_reg;
        hop_we        = 1'b0;
        inf_next      = inf_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        steps_next    = steps_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        dist_a_next   = dist_a_reg;
        p_valid_next  = p_valid_reg;
        p_b_next      = p_b_reg;
        last_next     = last_reg;
        cur_next      = cur_reg;
        has_next      = has_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_data_next = out_data_reg;
        edge_we       = 1'b0;
        edge_wa       = edge_addr(es_reg, ed_reg);
        edge_wd       = {est_reg, ec_reg};
        edge_ra       = edge_addr(rd_s, dst_reg);
        path_we       = 1'b0;
        path_wa       = x_reg;
        path_wd       = '0;
        path_ra       = x_reg;

        unique case (state_reg)
            // Sweep the link table to no link and a zero stamp.
            ST_CLEAR:
            begin
                edge_we      = 1'b1;
                edge_wa      = clr_cnt_reg;
                edge_wd      = {{STAMP_W{1'b0}}, {COST_W{1'b1}}};
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            // Capture the item and clear the result fields.
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = s_tuser;
                    src_next   = s_tdata[5:0];
                    dst_next   = s_tdata[11:6];
                    cost_next  = s_tdata[43:12];
                    stamp_next = s_tdata[74:44];
                    alive_next = s_tdata[75];
                    acc_next   = 1'b0;
                    send_next  = 1'b0;
                    reach_next = 1'b0;
                    nh_next    = '0;
                end
            end
            ST_READ:
                edge_ra = edge_addr(rd_s, dst_reg);
            // Decide the operation from the stored entry.
            ST_EVAL:
            begin
                prev_next = stored_cost;
                es_next   = rd_s;
                ed_next   = dst_reg;
                case (op_reg)
                    OP_REMOTE:
                    begin
                        if (item_ok && stored_stamp < stamp_reg)
                        begin
                            acc_next = 1'b1;
                            if (stamp_reg > clock_reg)
                                clock_next = stamp_reg;
                            ec_next  = cost_reg;
                            est_next = stamp_reg;
                        end
                    end
                    OP_LOCAL, OP_LIVE:
                    begin
                        if (item_ok)
                        begin
                            clock_next = clock_inc;
                            est_next   = clock_inc;
                            if (op_reg == OP_LOCAL)
                                ec_next = cost_reg;
                            else
                                ec_next = alive_reg ? live_mag : -live_mag;
                        end
                    end
                    OP_BEAT:
                    begin
                        if (beat_val > clock_reg)
                            clock_next = beat_val;
                    end
                    OP_LOOKUP:
                    begin
                        if (node_ok(dst_reg) && hop_valid_reg[dst_reg])
                        begin
                            reach_next = 1'b1;
                            nh_next    = hop_rd_reg;
                        end
                    end
                    default:
                    begin
                        clock_next = clock_reg;
                    end
                endcase
            end
            ST_WR_FWD:
            begin
                edge_we = 1'b1;
                edge_wa = edge_addr(es_reg, ed_reg);
            end
            // Reverse entry; a real change raises the clock and starts a rebuild.
            ST_WR_REV:
            begin
                edge_we           = 1'b1;
                edge_wa           = edge_addr(ed_reg, es_reg);
                known_next[es_reg] = 1'b1;
                known_next[ed_reg] = 1'b1;
                if (prev_reg != ec_reg)
                begin
                    clock_next = clock_inc;
                    send_next  = 1'b1;
                    x_next     = '0;
                    n_next     = '0;
                end
            end
            // Reset path entries and count the known nodes.
            ST_RB_INIT:
            begin
                path_we = 1'b1;
                path_wa = x_reg;
                n_next  = n_reg + CNT_W'(known_reg[node_x]);
                if (x_reg == '0)
                begin
                    inf_next       = '1;
                    hop_valid_next = '0;
                end
                x_next = x_reg + NODE_W'(1);
                if (x_last)
                begin
                    inf_next[my_id_reg] = 1'b0;
                    x_next = '0;
                    k_next = '0;
                end
            end
            // Pick the next reachable parent candidate.
            ST_RB_X:
            begin
                path_ra = x_reg;
                if (!(known_reg[node_x] && !inf_reg[node_x]))
                begin
                    x_next = x_reg + NODE_W'(1);
                    if (x_last)
                    begin
                        k_next = k_reg + CNT_W'(1);
                        x_next = '0;
                    end
                end
            end
            ST_RB_XD:
            begin
                dist_a_next  = path_rd_reg[DIST_W-1:0];
                y_next       = '0;
                p_valid_next = 1'b0;
            end
            // Issue one target per cycle and relax the one issued before.
            ST_RB_Y, ST_RB_DRAIN:
            begin
                if (relax_hit)
                begin
                    path_we           = 1'b1;
                    path_wa           = NODE_W'(p_b_reg);
                    path_wd           = {1'b1, node_a, relax_nd};
                    inf_next[p_b_reg] = 1'b0;
                end
                if (state_reg == ST_RB_Y)
                begin
                    edge_ra      = edge_addr(node_a, node_y);
                    path_ra      = y_reg;
                    p_valid_next = known_reg[node_y] && (node_y != node_a);
                    p_b_next     = node_y;
                    y_next       = y_reg + NODE_W'(1);
                end
                else
                begin
                    p_valid_next = 1'b0;
                    x_next       = x_reg + NODE_W'(1);
                    if (x_last)
                    begin
                        k_next = k_reg + CNT_W'(1);
                        x_next = '0;
                    end
                end
            end
            // Start the parent walk of one node.
            ST_WK_I:
            begin
                path_ra    = x_reg;
                last_next  = node_x;
                steps_next = '0;
                if (node_x == my_id_reg)
                    x_next = x_reg + NODE_W'(1);
            end
            ST_WK_R:
            begin
                has_next = path_rd_reg[DIST_W+ID_W];
                cur_next = path_rd_reg[DIST_W+ID_W-1:DIST_W];
            end
            // One step up the parent chain.
            ST_WK_S:
            begin
                if (has_reg && steps_reg != CNT_W'(NODES))
                begin
                    if (cur_reg == my_id_reg)
                    begin
                        hop_valid_next[node_x] = 1'b1;
                        hop_we = 1'b1;
                        x_next = x_reg + NODE_W'(1);
                    end
                    else
                    begin
                        last_next  = cur_reg;
                        path_ra    = NODE_W'(cur_reg);
                        steps_next = steps_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    x_next = x_reg + NODE_W'(1);
                end
            end
            // Hand the result to the output register.
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_data_next = {5'b0, clock_reg,
                                     send_reg ? est_reg : {STAMP_W{1'b0}},
                                     send_reg ? ec_reg : {COST_W{1'b0}},
                                     send_reg ? ed_reg : {ID_W{1'b0}},
                                     send_reg ? es_reg : {ID_W{1'b0}},
                                     send_reg, acc_reg, reach_reg, nh_reg};
                end
            end
            default:
            begin
                clr_cnt_next = clr_cnt_reg;
            end
        endcase
    end

    // Control and payload registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            op_reg        <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            cost_reg      <= '0;
            stamp_reg     <= '0;
            alive_reg     <= 1'b0;
            clock_reg     <= STAMP_W'(1);
            es_reg        <= '0;
            ed_reg        <= '0;
            ec_reg        <= '0;
            est_reg       <= '0;
            prev_reg      <= '0;
            acc_reg       <= 1'b0;
            send_reg      <= 1'b0;
            reach_reg     <= 1'b0;
            nh_reg        <= '0;
            known_reg     <= '0;
            hop_valid_reg <= '0;
            inf_reg       <= '1;
            n_reg         <= '0;
            k_reg         <= '0;
            steps_reg     <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            dist_a_reg    <= '0;
            p_valid_reg   <= 1'b0;
            p_b_reg       <= '0;
            last_reg      <= '0;
            cur_reg       <= '0;
            has_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            op_reg        <= op_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            cost_reg      <= cost_next;
            stamp_reg     <= stamp_next;
            alive_reg     <= alive_next;
            clock_reg     <= clock_next;
            es_reg        <= es_next;
            ed_reg        <= ed_next;
            ec_reg        <= ec_next;
            est_reg       <= est_next;
            prev_reg      <= prev_next;
            acc_reg       <= acc_next;
            send_reg      <= send_next;
            reach_reg     <= reach_next;
            nh_reg        <= nh_next;
            known_reg     <= known_next;
            hop_valid_reg <= hop_valid_next;
            inf_reg       <= inf_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            steps_reg     <= steps_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            dist_a_reg    <= dist_a_next;
            p_valid_reg   <= p_valid_next;
            p_b_reg       <= p_b_next;
            last_reg      <= last_next;
            cur_reg       <= cur_next;
            has_reg       <= has_next;
            m_tvalid_reg  <= m_tvalid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            my_id_reg <= '0;
        else if (cfg_wr_en)
            my_id_reg <= cfg_wr_data;
    end

    // Link memory with registered read.
    always_ff @(posedge clk)
    begin
        if (edge_we)
            edge_mem[edge_wa] <= edge_wd;
        edge_rd_reg <= edge_mem[edge_ra];
    end

    // Path memory with registered read.
    always_ff @(posedge clk)
    begin
        if (path_we)
            path_mem[path_wa] <= path_wd;
        path_rd_reg <= path_mem[path_ra];
    end

    // Next-hop memory; the lookup target is read while the item is decoded.
    always_ff @(posedge clk)
    begin
        if (hop_we)
            hop_mem[x_reg] <= last_reg;
        hop_rd_reg <= hop_mem[dst_reg];
    end

endmodule

`default_nettype wire

// File: design/lsre_checker.sv
// ----------------------------------------------------------------------------
// Link-state route engine checker
// Port-level assertions on the route engine, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_state_route_engine_core_assert.svh"

module lsre_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [lsre_pkg::OUT_W-1:0] m_tdata
);
    import lsre_pkg::*;

    // A stalled result stays offered.
    `LSRE_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // The block is busy right after taking an item.
    `LSRE_ASSERT_NXT(a_busy_after_in, s_tvalid && s_tready, !s_tready, "ready right after a transfer")

    // A reachable lookup never reports an accepted update or a rebroadcast.
    `LSRE_ASSERT_IMP(a_lookup_clean, m_tvalid && m_tdata[6], !m_tdata[7] && !m_tdata[8],
        "lookup result carries update flags")

    // Without a rebroadcast the update fields are all zero.
    `LSRE_ASSERT_IMP(a_update_zero, m_tvalid && !m_tdata[8], m_tdata[83:9] == '0,
        "update fields set without rebroadcast")

endmodule

bind link_state_route_engine_core lsre_checker u_lsre_checker (.*);

`default_nettype wire
